FILE: design/ket_pkg.sv
// Shared types and constants for the keyed entry table.
// Used by ket_cell and keyed_entry_table; depends on nothing else.
`timescale 1ns / 1ps

package ket_pkg;

    localparam int ID_W       = 32;
    localparam int PAY_PORT_W = 64;
    localparam int CAP_W      = 5;
    localparam int CNT_OUT_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Per-cycle command broadcast from the controller to every cell.
    typedef struct packed {
        logic cmp_en;
        logic sel_en;
        logic do_append;
        logic do_remove;
        logic do_update;
    } t_cell_cmd;

endpackage

FILE: design/ket_cell.sv
// One slot of the keyed entry table: holds an id and a payload, compares it
// against the search key and passes match and readout chains to its neighbors.
// Depends on ket_pkg.
`timescale 1ns / 1ps

module ket_cell #(
    parameter int INDEX        = 0,
    parameter int CNT_W        = 5,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ket_pkg::t_cell_cmd           i_cmd,
    input  logic [CNT_W-1:0]             i_count,
    input  logic [ket_pkg::ID_W-1:0]     i_search_key,
    input  logic [ket_pkg::ID_W-1:0]     i_new_id,
    input  logic [PAYLOAD_BITS-1:0]      i_new_pay,
    input  logic [ket_pkg::ID_W-1:0]     i_next_id,
    input  logic [PAYLOAD_BITS-1:0]      i_next_pay,
    input  logic                         i_seen_lo,
    output logic                         o_seen_lo,
    input  logic                         i_seen_hi,
    output logic                         o_seen_hi,
    input  logic [ket_pkg::ID_W-1:0]     i_found_id,
    input  logic [PAYLOAD_BITS-1:0]      i_found_pay,
    output logic [ket_pkg::ID_W-1:0]     o_found_id,
    output logic [PAYLOAD_BITS-1:0]      o_found_pay,
    output logic [ket_pkg::ID_W-1:0]     o_id,
    output logic [PAYLOAD_BITS-1:0]      o_pay,
    output logic                         o_first,
    output logic                         o_last
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [ket_pkg::ID_W-1:0] r_id;
    logic [PAYLOAD_BITS-1:0]  r_pay;
    logic                     r_hit;
    logic                     r_first;
    logic                     r_last;
    logic                     r_shift;
    logic                     in_use;
    logic                     at_tail;

    assign in_use  = IDX < i_count;
    assign at_tail = IDX == i_count;

    assign o_seen_lo   = i_seen_lo | r_hit;
    assign o_seen_hi   = i_seen_hi | r_hit;
    assign o_found_id  = r_first ? r_id : i_found_id;
    assign o_found_pay = r_first ? r_pay : i_found_pay;
    assign o_id        = r_id;
    assign o_pay       = r_pay;
    assign o_first     = r_first;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_first <= 1'b0;
            r_last  <= 1'b0;
            r_shift <= 1'b0;
        end else begin
            if (i_cmd.cmp_en) begin
                r_hit <= in_use && (r_id == i_search_key);
            end
            // First match has no hit below it, last match none above it.
            // Every cell at or past the first match takes its upper neighbor on delete.
            if (i_cmd.sel_en) begin
                r_first <= r_hit & ~i_seen_lo;
                r_last  <= r_hit & ~i_seen_hi;
                r_shift <= i_seen_lo | r_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_append && at_tail) begin
            r_id  <= i_new_id;
            r_pay <= i_new_pay;
        end else if (i_cmd.do_update && r_last) begin
            r_id  <= i_new_id;
            r_pay <= i_new_pay;
        end else if (i_cmd.do_remove && r_shift) begin
            r_id  <= i_next_id;
            r_pay <= i_next_pay;
        end
    end

endmodule

FILE: design/keyed_entry_table.sv
// Keyed entry table: up to DEPTH entries (signed 32-bit id plus payload) in
// insertion order, with add, delete (compacting), update-last and get-first.
// Depends on ket_pkg and ket_cell.
`timescale 1ns / 1ps

// Each transaction runs through capture, a compare in every cell at once, a
// registered selection of first and last match flags rippled along the row of
// cells, and a commit that writes the cells and loads the result register. A
// new transaction is taken in the cycle after the commit, so no new item is
// taken before the last one has committed; the commit waits while the result
// register is still full and not being taken. The table needs no clearing
// after reset. The capacity register is limited to DEPTH when used.
module keyed_entry_table #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ket_pkg::CAP_W-1:0]             i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_op,
    input  logic signed [ket_pkg::ID_W-1:0]       i_key,
    input  logic signed [ket_pkg::ID_W-1:0]       i_entry_id,
    input  logic [ket_pkg::PAY_PORT_W-1:0]        i_entry_payload,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [1:0]                            o_status,
    output logic signed [ket_pkg::ID_W-1:0]       o_found_id,
    output logic [ket_pkg::PAY_PORT_W-1:0]        o_found_payload,
    output logic [ket_pkg::CNT_OUT_W-1:0]         o_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CX    = ((CNT_W > ket_pkg::CAP_W) ? CNT_W : ket_pkg::CAP_W) + 1;
    localparam logic [CX-1:0] DEPTH_X = CX'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CMP    = 4'b0010,
        S_SEL    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    ket_pkg::t_op                  r_op;
    logic [ket_pkg::ID_W-1:0]      r_key;
    logic [ket_pkg::ID_W-1:0]      r_eid;
    logic [PAYLOAD_BITS-1:0]       r_epay;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [ket_pkg::CAP_W-1:0]     r_capacity;
    logic                          r_any;
    logic                          r_out_valid;
    ket_pkg::t_status              r_status, n_status;
    logic [ket_pkg::ID_W-1:0]      r_found_id;
    logic [ket_pkg::PAY_PORT_W-1:0] r_found_pay;
    logic [ket_pkg::CNT_OUT_W-1:0] r_entry_count;

    ket_pkg::t_cell_cmd            cmd;
    logic                          accept;
    logic                          out_free;
    logic                          commit;
    logic                          full;
    logic [CX-1:0]                 count_x;
    logic [CX-1:0]                 cap_x;
    logic [CX-1:0]                 n_count_x;
    logic [ket_pkg::ID_W-1:0]      search_key;

    logic                          seen_lo   [0:DEPTH];
    logic                          seen_hi   [0:DEPTH];
    logic [ket_pkg::ID_W-1:0]      found_id  [0:DEPTH];
    logic [PAYLOAD_BITS-1:0]       found_pay [0:DEPTH];
    logic [ket_pkg::ID_W-1:0]      cell_id   [0:DEPTH-1];
    logic [PAYLOAD_BITS-1:0]       cell_pay  [0:DEPTH-1];
    logic [DEPTH-1:0]              first_vec;
    logic [DEPTH-1:0]              last_vec;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_COMMIT) && out_free;
    assign search_key = (r_op == ket_pkg::OP_ADD) ? r_eid : r_key;

    assign count_x = CX'(r_count);
    assign cap_x   = (CX'(r_capacity) > DEPTH_X) ? DEPTH_X : CX'(r_capacity);
    assign full    = ((count_x + CX'(1)) > cap_x) || (count_x >= DEPTH_X);

    always_comb begin
        n_status = ket_pkg::ST_OK;
        case (r_op)
            ket_pkg::OP_ADD: begin
                if (full) begin
                    n_status = ket_pkg::ST_FULL;
                end else if (r_any) begin
                    n_status = ket_pkg::ST_DUP;
                end
            end
            default: begin
                if (!r_any) begin
                    n_status = ket_pkg::ST_MISSING;
                end
            end
        endcase
    end

    always_comb begin
        cmd.cmp_en    = (r_state == S_CMP);
        cmd.sel_en    = (r_state == S_SEL);
        cmd.do_append = commit && (r_op == ket_pkg::OP_ADD) && (n_status == ket_pkg::ST_OK);
        cmd.do_remove = commit && (r_op == ket_pkg::OP_DELETE) && (n_status == ket_pkg::ST_OK);
        cmd.do_update = commit && (r_op == ket_pkg::OP_UPDATE) && (n_status == ket_pkg::ST_OK);
    end

    always_comb begin
        n_count = r_count;
        if (cmd.do_append) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign n_count_x = CX'(n_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_CMP;
            S_CMP:    n_state = S_SEL;
            S_SEL:    n_state = S_COMMIT;
            S_COMMIT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign seen_lo[0]     = 1'b0;
    assign seen_hi[DEPTH] = 1'b0;
    assign found_id[0]    = '0;
    assign found_pay[0]   = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ket_pkg::ID_W-1:0] next_id;
        logic [PAYLOAD_BITS-1:0]  next_pay;

        // The top cell has no upper neighbor and keeps its own contents on delete.
        if (g == DEPTH - 1) begin : g_top
            assign next_id  = cell_id[g];
            assign next_pay = cell_pay[g];
        end else begin : g_mid
            assign next_id  = cell_id[g+1];
            assign next_pay = cell_pay[g+1];
        end

        ket_cell #(
            .INDEX        (g),
            .CNT_W        (CNT_W),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_count      (r_count),
            .i_search_key (search_key),
            .i_new_id     (r_eid),
            .i_new_pay    (r_epay),
            .i_next_id    (next_id),
            .i_next_pay   (next_pay),
            .i_seen_lo    (seen_lo[g]),
            .o_seen_lo    (seen_lo[g+1]),
            .i_seen_hi    (seen_hi[g+1]),
            .o_seen_hi    (seen_hi[g]),
            .i_found_id   (found_id[g]),
            .i_found_pay  (found_pay[g]),
            .o_found_id   (found_id[g+1]),
            .o_found_pay  (found_pay[g+1]),
            .o_id         (cell_id[g]),
            .o_pay        (cell_pay[g]),
            .o_first      (first_vec[g]),
            .o_last       (last_vec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= ket_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= ket_pkg::t_op'(i_op);
            r_key  <= i_key;
            r_eid  <= i_entry_id;
            r_epay <= i_entry_payload[PAYLOAD_BITS-1:0];
        end
        if (r_state == S_SEL) begin
            r_any <= seen_lo[DEPTH];
        end
        if (commit) begin
            r_status      <= n_status;
            r_entry_count <= n_count_x[ket_pkg::CNT_OUT_W-1:0];
            if ((r_op == ket_pkg::OP_GET) && r_any) begin
                r_found_id  <= found_id[DEPTH];
                r_found_pay <= ket_pkg::PAY_PORT_W'(found_pay[DEPTH]);
            end else begin
                r_found_id  <= '0;
                r_found_pay <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_found_id      = r_found_id;
    assign o_found_payload = r_found_pay;
    assign o_entry_count   = r_entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_x <= DEPTH_X)
        else $error("entry count exceeds table depth");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> ($onehot0(first_vec) && $onehot0(last_vec)))
        else $error("more than one first or last match in the row");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.do_append |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("successful add did not grow the table by one");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (n_status != ket_pkg::ST_OK)) |=> $stable(r_count))
        else $error("failed transaction changed the entry count");

endmodule
